/* rtl/core/bra_pkg.sv */
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types, command and status codes, and saturation helper for the
// resource allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

   localparam int AMT_W   = 16;
   localparam int NEED_W  = 17;
   localparam int AVAIL_W = 18;
   localparam int WIDE_W  = 24;
   localparam int ENTRY_W = AMT_W + NEED_W;

   typedef logic [2:0] cmd_type;
   typedef logic [2:0] status_type;
   typedef logic [1:0] csr_idx_type;

   localparam cmd_type CMD_LOAD_PROC  = 3'd0;
   localparam cmd_type CMD_LOAD_TOTAL = 3'd1;
   localparam cmd_type CMD_REQUEST    = 3'd2;
   localparam cmd_type CMD_RELEASE    = 3'd3;
   localparam cmd_type CMD_CHECK      = 3'd4;

   localparam status_type STS_RELEASED      = 3'd0;
   localparam status_type STS_GRANTED       = 3'd1;
   localparam status_type STS_NO_AVAIL      = 3'd2;
   localparam status_type STS_UNSAFE_DENIED = 3'd3;
   localparam status_type STS_EXCEEDS_NEED  = 3'd4;
   localparam status_type STS_SAFE          = 3'd5;
   localparam status_type STS_UNSAFE        = 3'd6;

   localparam csr_idx_type CSR_NUM_PROCS = 2'd0;
   localparam csr_idx_type CSR_NUM_RES   = 2'd1;

   typedef logic signed [AVAIL_W-1:0] avail_type;
   typedef logic signed [NEED_W-1:0]  need_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   localparam wide_type SAT_HI = 24'sd131071;
   localparam wide_type SAT_LO = -24'sd131072;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_CLEAR  = 12'b0000_0000_0010,
      S_ONE_WR = 12'b0000_0000_0100,
      S_CHK    = 12'b0000_0000_1000,
      S_APPLY  = 12'b0000_0001_0000,
      S_REVERT = 12'b0000_0010_0000,
      S_INIT   = 12'b0000_0100_0000,
      S_PICK   = 12'b0000_1000_0000,
      S_ROW    = 12'b0001_0000_0000,
      S_ADD    = 12'b0010_0000_0000,
      S_END    = 12'b0100_0000_0000,
      S_SPARE  = 12'b1000_0000_0000
   } state_type;

   function automatic avail_type sat18(input wide_type v);
      avail_type r;
      if (v > SAT_HI) begin
         r = SAT_HI[AVAIL_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[AVAIL_W-1:0];
      end else begin
         r = v[AVAIL_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/bra_ram.sv */
// ----------------------------------------------------------------------------
// bra_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/bra_ctrl.sv */
// ----------------------------------------------------------------------------
// bra_ctrl
// Sequencer and datapath: clearing pass, loads, releases, request
// check/apply/revert sweeps over the allocation/need memory, and the cyclic safety scan.
// ----------------------------------------------------------------------------
module bra_ctrl import bra_pkg::*; #(
   parameter int MAX_PROCS = 8,
   parameter int MAX_RES   = 8,
   parameter int NPW       = 4,
   parameter int NRW       = 4,
   parameter int AW        = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  cmd_type            req_cmd,
   input  logic [2:0]         req_proc_id,
   input  logic [2:0]         req_res_id,
   input  logic [AMT_W-1:0]   req_amount,
   input  logic [AMT_W-1:0]   req_max_claim,
   input  logic               req_last,
   input  logic [NPW-1:0]     np,
   input  logic [NRW-1:0]     nr,
   output logic               mem_we,
   output logic [AW-1:0]      mem_waddr,
   output logic [ENTRY_W-1:0] mem_wdata,
   output logic [AW-1:0]      mem_raddr,
   input  logic [ENTRY_W-1:0] mem_rdata,
   output logic               rsp_valid,
   output logic [2:0]         rsp_proc_out,
   output status_type         rsp_status
);

   localparam int PIDW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int RIDW  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int DEPTH = MAX_PROCS * MAX_RES;
   localparam int CSW   = AMT_W + PIDW;

   state_type state_ff, state_in;
   logic [NRW-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [AW-1:0]   addr_q_ff, addr_q_in;
   logic [PIDW-1:0] row_ff, row_in;
   logic [PIDW-1:0] scan_ff, scan_in;
   logic [RIDW-1:0] res_ff, res_in;
   logic [NPW-1:0]  idle_ff, idle_in;
   logic [AMT_W-1:0] amt_ff, amt_in;
   logic [AMT_W-1:0] claim_ff, claim_in;
   logic            last_ff, last_in;
   logic [2:0]      proc_ff, proc_in;
   logic            is_rel_ff, is_rel_in;
   logic            is_req_ff, is_req_in;
   logic            exceed_ff, exceed_in;
   logic            nofit_ff, nofit_in;
   logic            fit_ff, fit_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_proc_ff, rsp_proc_in;
   status_type      rsp_status_ff, rsp_status_in;

   logic [AMT_W-1:0] reqbuf_ff [MAX_RES];
   logic [AMT_W-1:0] reqbuf_in [MAX_RES];
   avail_type        work_ff   [MAX_RES];
   avail_type        work_in   [MAX_RES];
   logic [AMT_W-1:0] ralloc_ff [MAX_RES];
   logic [AMT_W-1:0] ralloc_in [MAX_RES];
   logic [CSW-1:0]   colsum_ff [MAX_RES];
   logic [CSW-1:0]   colsum_in [MAX_RES];
   logic [AMT_W-1:0] total_ff  [MAX_RES];
   logic [AMT_W-1:0] total_in  [MAX_RES];
   logic             finish_ff [MAX_PROCS];
   logic             finish_in [MAX_PROCS];

   avail_type        avail_lane [MAX_RES];

   logic             p_ok, r_ok;
   logic [PIDW-1:0]  prow, srow, scan_next;
   logic [RIDW-1:0]  rres, e_idx;
   logic [AMT_W-1:0] q_alloc, req_e, rel_amt;
   need_type         q_need;
   avail_type        avail_e, work_e;
   logic             proc_en, issue_en, last_el;
   logic             over_need, over_avail, row_block, all_done;

   function automatic logic [AW-1:0] ent_addr(input logic [PIDW-1:0] r,
                                              input logic [RIDW-1:0] c);
      return AW'(r) * AW'(MAX_RES) + AW'(c);
   endfunction

   always_comb begin
      for (int i = 0; i < MAX_RES; i++) begin
         avail_lane[i] = sat18($signed({{(WIDE_W-AMT_W){1'b0}}, total_ff[i]})
                               - $signed({{(WIDE_W-CSW){1'b0}}, colsum_ff[i]}));
      end
   end

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < MAX_PROCS; i++) begin
         if (i < int'(np) && !finish_ff[i]) begin
            all_done = 1'b0;
         end
      end
   end

   assign p_ok      = int'(req_proc_id) < int'(np);
   assign r_ok      = int'(req_res_id) < int'(nr);
   assign prow      = PIDW'(req_proc_id);
   assign rres      = RIDW'(req_res_id);
   assign srow      = (state_ff == S_ROW) ? scan_ff : row_ff;
   assign scan_next = (int'(scan_ff) == int'(np) - 1) ? '0 : scan_ff + 1'b1;

   assign e_idx    = RIDW'(cnt_ff - 1'b1);
   assign proc_en  = cnt_ff != '0;
   assign issue_en = cnt_ff < nr;
   assign last_el  = cnt_ff == nr;

   assign q_alloc  = mem_rdata[ENTRY_W-1:NEED_W];
   assign q_need   = $signed(mem_rdata[NEED_W-1:0]);
   assign req_e    = reqbuf_ff[e_idx];
   assign avail_e  = avail_lane[e_idx];
   assign work_e   = work_ff[e_idx];
   assign rel_amt  = (amt_ff > q_alloc) ? q_alloc : amt_ff;

   assign over_need  = $signed({1'b0, req_e}) > q_need;
   assign over_avail = $signed({2'b0, req_e}) > avail_e;
   assign row_block  = $signed({q_need[NEED_W-1], q_need}) > work_e;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      clr_in        = clr_ff;
      addr_q_in     = addr_q_ff;
      row_in        = row_ff;
      scan_in       = scan_ff;
      res_in        = res_ff;
      idle_in       = idle_ff;
      amt_in        = amt_ff;
      claim_in      = claim_ff;
      last_in       = last_ff;
      proc_in       = proc_ff;
      is_rel_in     = is_rel_ff;
      is_req_in     = is_req_ff;
      exceed_in     = exceed_ff;
      nofit_in      = nofit_ff;
      fit_in        = fit_ff;
      rsp_valid_in  = 1'b0;
      rsp_proc_in   = rsp_proc_ff;
      rsp_status_in = rsp_status_ff;
      reqbuf_in     = reqbuf_ff;
      work_in       = work_ff;
      ralloc_in     = ralloc_ff;
      colsum_in     = colsum_ff;
      total_in      = total_ff;
      finish_in     = finish_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_q_ff;
      mem_wdata     = '0;
      mem_raddr     = addr_q_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (start) begin
               case (req_cmd)
                  CMD_LOAD_PROC: begin
                     if (p_ok && r_ok) begin
                        mem_raddr = ent_addr(prow, rres);
                        addr_q_in = ent_addr(prow, rres);
                        res_in    = rres;
                        amt_in    = req_amount;
                        claim_in  = req_max_claim;
                        is_rel_in = 1'b0;
                        last_in   = 1'b0;
                        state_in  = S_ONE_WR;
                     end
                  end
                  CMD_LOAD_TOTAL: begin
                     if (r_ok) begin
                        total_in[rres] = req_amount;
                     end
                  end
                  CMD_REQUEST: begin
                     if (r_ok) begin
                        reqbuf_in[rres] = req_amount;
                     end
                     if (req_last) begin
                        proc_in = req_proc_id;
                        row_in  = prow;
                        if (!p_ok) begin
                           rsp_valid_in  = 1'b1;
                           rsp_proc_in   = req_proc_id;
                           rsp_status_in = STS_EXCEEDS_NEED;
                        end else begin
                           exceed_in = 1'b0;
                           nofit_in  = 1'b0;
                           is_req_in = 1'b1;
                           cnt_in    = '0;
                           state_in  = S_CHK;
                        end
                     end
                  end
                  CMD_RELEASE: begin
                     if (p_ok && r_ok) begin
                        mem_raddr = ent_addr(prow, rres);
                        addr_q_in = ent_addr(prow, rres);
                        res_in    = rres;
                        amt_in    = req_amount;
                        is_rel_in = 1'b1;
                        last_in   = req_last;
                        proc_in   = req_proc_id;
                        state_in  = S_ONE_WR;
                     end else if (req_last) begin
                        rsp_valid_in  = 1'b1;
                        rsp_proc_in   = req_proc_id;
                        rsp_status_in = STS_RELEASED;
                     end
                  end
                  CMD_CHECK: begin
                     is_req_in = 1'b0;
                     proc_in   = 3'd0;
                     state_in  = S_INIT;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_ONE_WR: begin
            mem_we = 1'b1;
            if (is_rel_ff) begin
               mem_wdata = {q_alloc - rel_amt, q_need + $signed({1'b0, rel_amt})};
               colsum_in[res_ff] = colsum_ff[res_ff] - CSW'(rel_amt);
               if (last_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_proc_in   = proc_ff;
                  rsp_status_in = STS_RELEASED;
               end
            end else begin
               mem_wdata = {amt_ff, $signed({1'b0, claim_ff}) - $signed({1'b0, amt_ff})};
               colsum_in[res_ff] = colsum_ff[res_ff] - CSW'(q_alloc) + CSW'(amt_ff);
            end
            state_in = S_IDLE;
         end

         S_CHK, S_APPLY, S_REVERT, S_ROW: begin
            if (issue_en) begin
               mem_raddr = ent_addr(srow, RIDW'(cnt_ff));
               addr_q_in = ent_addr(srow, RIDW'(cnt_ff));
            end
            cnt_in = cnt_ff + 1'b1;
            case (state_ff)
               S_CHK: begin
                  exceed_in = exceed_ff | (proc_en & over_need);
                  nofit_in  = nofit_ff | (proc_en & over_avail);
                  if (last_el) begin
                     if (exceed_in) begin
                        rsp_valid_in  = 1'b1;
                        rsp_proc_in   = proc_ff;
                        rsp_status_in = STS_EXCEEDS_NEED;
                        state_in      = S_IDLE;
                     end else if (nofit_in) begin
                        rsp_valid_in  = 1'b1;
                        rsp_proc_in   = proc_ff;
                        rsp_status_in = STS_NO_AVAIL;
                        state_in      = S_IDLE;
                     end else begin
                        cnt_in   = '0;
                        state_in = S_APPLY;
                     end
                  end
               end
               S_APPLY: begin
                  if (proc_en) begin
                     mem_we    = 1'b1;
                     mem_wdata = {q_alloc + req_e, q_need - $signed({1'b0, req_e})};
                     colsum_in[e_idx] = colsum_ff[e_idx] + CSW'(req_e);
                  end
                  if (last_el) begin
                     state_in = S_INIT;
                  end
               end
               S_REVERT: begin
                  if (proc_en) begin
                     mem_we    = 1'b1;
                     mem_wdata = {q_alloc - req_e, q_need + $signed({1'b0, req_e})};
                     colsum_in[e_idx] = colsum_ff[e_idx] - CSW'(req_e);
                  end
                  if (last_el) begin
                     rsp_valid_in  = 1'b1;
                     rsp_proc_in   = proc_ff;
                     rsp_status_in = STS_UNSAFE_DENIED;
                     state_in      = S_IDLE;
                  end
               end
               default: begin
                  fit_in = fit_ff & ~(proc_en & row_block);
                  if (proc_en) begin
                     ralloc_in[e_idx] = q_alloc;
                  end
                  if (last_el) begin
                     if (fit_in) begin
                        state_in = S_ADD;
                     end else begin
                        idle_in  = idle_ff + 1'b1;
                        scan_in  = scan_next;
                        state_in = S_PICK;
                     end
                  end
               end
            endcase
         end

         S_INIT: begin
            for (int i = 0; i < MAX_RES; i++) begin
               if (i < int'(nr)) begin
                  work_in[i] = avail_lane[i];
               end
            end
            for (int i = 0; i < MAX_PROCS; i++) begin
               finish_in[i] = 1'b0;
            end
            scan_in  = '0;
            idle_in  = '0;
            state_in = S_PICK;
         end

         S_PICK: begin
            if (int'(idle_ff) >= int'(np)) begin
               state_in = S_END;
            end else if (finish_ff[scan_ff]) begin
               idle_in = idle_ff + 1'b1;
               scan_in = scan_next;
            end else begin
               fit_in   = 1'b1;
               cnt_in   = '0;
               state_in = S_ROW;
            end
         end

         S_ADD: begin
            for (int i = 0; i < MAX_RES; i++) begin
               if (i < int'(nr)) begin
                  work_in[i] = sat18($signed({{(WIDE_W-AVAIL_W){work_ff[i][AVAIL_W-1]}},
                                              work_ff[i]})
                                     + $signed({{(WIDE_W-AMT_W){1'b0}}, ralloc_ff[i]}));
               end
            end
            finish_in[scan_ff] = 1'b1;
            idle_in  = NPW'(1);
            scan_in  = scan_next;
            state_in = S_PICK;
         end

         S_END: begin
            if (is_req_ff) begin
               if (all_done) begin
                  rsp_valid_in  = 1'b1;
                  rsp_proc_in   = proc_ff;
                  rsp_status_in = STS_GRANTED;
                  state_in      = S_IDLE;
               end else begin
                  cnt_in   = '0;
                  state_in = S_REVERT;
               end
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_proc_in   = 3'd0;
               rsp_status_in = all_done ? STS_SAFE : STS_UNSAFE;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         idle_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_RES; i++) begin
            colsum_ff[i] <= '0;
            total_ff[i]  <= '0;
         end
         for (int i = 0; i < MAX_PROCS; i++) begin
            finish_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         idle_ff      <= idle_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         colsum_ff    <= colsum_in;
         total_ff     <= total_in;
         finish_ff    <= finish_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_q_ff     <= addr_q_in;
      row_ff        <= row_in;
      res_ff        <= res_in;
      amt_ff        <= amt_in;
      claim_ff      <= claim_in;
      last_ff       <= last_in;
      proc_ff       <= proc_in;
      is_rel_ff     <= is_rel_in;
      is_req_ff     <= is_req_in;
      exceed_ff     <= exceed_in;
      nofit_ff      <= nofit_in;
      fit_ff        <= fit_in;
      rsp_proc_ff   <= rsp_proc_in;
      rsp_status_ff <= rsp_status_in;
      reqbuf_ff     <= reqbuf_in;
      work_ff       <= work_in;
      ralloc_ff     <= ralloc_in;
   end

   assign busy         = state_ff != S_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_proc_out = rsp_proc_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

/* rtl/core/bankers_resource_allocator.sv */
// Total load and non-last request element are taken in the idle state; process
// load and release element read the entry and write it back; a request adds
// check and apply sweeps over the row, plus a revert sweep when unsafe; a safety
// scan visits rows in turn, reads each unfinished row, adds each row that fits,
// at most np*np row reads; result strobe registered. One item at a time.
// After reset a clearing pass over MAX_PROCS*MAX_RES entries holds busy high.
// ----------------------------------------------------------------------------
// bankers_resource_allocator
// Deadlock-avoidance engine: configuration registers, memory and sequencer.
// ----------------------------------------------------------------------------
module bankers_resource_allocator import bra_pkg::*; #(
   parameter int MAX_PROCS = 8,
   parameter int MAX_RES   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cmd_type          req_cmd,
   input  logic [2:0]       req_proc_id,
   input  logic [2:0]       req_res_id,
   input  logic [AMT_W-1:0] req_amount,
   input  logic [AMT_W-1:0] req_max_claim,
   input  logic             req_last,
   output logic             rsp_valid,
   output logic [2:0]       rsp_proc_out,
   output status_type       rsp_status,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  csr_idx_type      csr_index,
   input  logic [3:0]       csr_wdata
);

   localparam int NPW   = $clog2(MAX_PROCS + 1);
   localparam int NRW   = $clog2(MAX_RES + 1);
   localparam int DEPTH = MAX_PROCS * MAX_RES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [3:0]         num_procs_ff, num_procs_in;
   logic [3:0]         num_res_ff, num_res_in;
   logic [NPW-1:0]     np;
   logic [NRW-1:0]     nr;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      num_procs_in = num_procs_ff;
      num_res_in   = num_res_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_PROCS: num_procs_in = csr_wdata;
            CSR_NUM_RES:   num_res_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_procs_ff <= 4'd8;
         num_res_ff   <= 4'd8;
      end else begin
         num_procs_ff <= num_procs_in;
         num_res_ff   <= num_res_in;
      end
   end

   assign np = (num_procs_ff == 4'd0) ? NPW'(1) :
               (int'(num_procs_ff) > MAX_PROCS) ? NPW'(MAX_PROCS) : NPW'(num_procs_ff);
   assign nr = (num_res_ff == 4'd0) ? NRW'(1) :
               (int'(num_res_ff) > MAX_RES) ? NRW'(MAX_RES) : NRW'(num_res_ff);

   bra_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mat_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   bra_ctrl #(
      .MAX_PROCS (MAX_PROCS),
      .MAX_RES   (MAX_RES),
      .NPW       (NPW),
      .NRW       (NRW),
      .AW        (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_proc_id   (req_proc_id),
      .req_res_id    (req_res_id),
      .req_amount    (req_amount),
      .req_max_claim (req_max_claim),
      .req_last      (req_last),
      .np            (np),
      .nr            (nr),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_proc_out  (rsp_proc_out),
      .rsp_status    (rsp_status)
   );

endmodule

/* rtl/core/bra_checker.sv */
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bra_checker import bra_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic [2:0] rsp_proc_out,
   input status_type rsp_status
);

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   a_check_proc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_SAFE || rsp_status == STS_UNSAFE)
      |-> rsp_proc_out == 3'd0)
      else $error("check result carries a process index");

   // grant or unsafe denial only after a safety scan
   a_scan_before_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STS_GRANTED || rsp_status == STS_UNSAFE_DENIED)
      |-> $past(busy))
      else $error("verdict without safety scan");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STS_UNSAFE)
      else $error("result status out of range");

endmodule

bind bankers_resource_allocator bra_checker u_bra_checker (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_proc_out (rsp_proc_out),
   .rsp_status   (rsp_status)
);
